[rtl/qspk_pkg.sv]
// Shared constants, saturating helpers and the arctangent table for the q-series phase kernel.
`default_nettype none
package qspk_pkg;

  localparam int unsigned WordWidth = 64;
  localparam int unsigned TermWidth = 13;
  localparam int unsigned CordicWidth = 34;
  localparam logic [TermWidth-1:0] TermCountReset = TermWidth'(256);
  localparam logic [WordWidth-1:0] OneFix = 64'h0000_0100_0000_0000;
  localparam logic [WordWidth-1:0] MaxFix = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [WordWidth-1:0] MinFix = 64'h8000_0000_0000_0000;
  localparam logic [31:0] HalfTurn = 32'h8000_0000;

  typedef struct packed {
    logic ovf;
    logic [WordWidth-1:0] val;
  } sat_res_t;

  function automatic sat_res_t sat_add(input logic [WordWidth-1:0] a,
                                       input logic [WordWidth-1:0] b);
    logic [WordWidth:0] s;
    sat_res_t r;
    s = {a[WordWidth-1], a} + {b[WordWidth-1], b};
    r.ovf = s[WordWidth] ^ s[WordWidth-1];
    r.val = r.ovf ? (s[WordWidth] ? MinFix : MaxFix) : s[WordWidth-1:0];
    return r;
  endfunction

  function automatic sat_res_t sat_sub(input logic [WordWidth-1:0] a,
                                       input logic [WordWidth-1:0] b);
    logic [WordWidth:0] s;
    sat_res_t r;
    s = {a[WordWidth-1], a} - {b[WordWidth-1], b};
    r.ovf = s[WordWidth] ^ s[WordWidth-1];
    r.val = r.ovf ? (s[WordWidth] ? MinFix : MaxFix) : s[WordWidth-1:0];
    return r;
  endfunction

  function automatic logic [WordWidth-1:0] mag(input logic [WordWidth-1:0] v);
    return v[WordWidth-1] ? (~v + 64'd1) : v;
  endfunction

  // Arctangent of 2^-i in units of 2^-32 turn.
  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0: r = 32'h20000000;  5'd1: r = 32'h12E4051E;  5'd2: r = 32'h09FB385B;
      5'd3: r = 32'h051111D4;  5'd4: r = 32'h028B0D43;  5'd5: r = 32'h0145D7E1;
      5'd6: r = 32'h00A2F61E;  5'd7: r = 32'h00517C55;  5'd8: r = 32'h0028BE53;
      5'd9: r = 32'h00145F2F;  5'd10: r = 32'h000A2F98; 5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6; 5'd13: r = 32'h000145F3; 5'd14: r = 32'h0000A2FA;
      5'd15: r = 32'h0000517D; 5'd16: r = 32'h000028BE; 5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30; 5'd19: r = 32'h00000518; 5'd20: r = 32'h0000028C;
      5'd21: r = 32'h00000146; 5'd22: r = 32'h000000A3; 5'd23: r = 32'h00000051;
      5'd24: r = 32'h00000029; 5'd25: r = 32'h00000014; 5'd26: r = 32'h0000000A;
      5'd27: r = 32'h00000005; 5'd28: r = 32'h00000003; 5'd29: r = 32'h00000001;
      5'd30: r = 32'h00000001;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

[rtl/q_series_phase_kernel.sv]
// Top level of the q-series phase kernel: series sequencer, shared multiplier and CORDIC.
`default_nettype none
// Each series term after the first runs S_DIFF for the differences, then eight 64x64 real
// products, each through one shared 32x32 multiplier as four partial products in S_MUL and a
// rounding step in S_FIN, with S_CMBF, S_ACC and S_CMBP for the combines and the running sum.
// Then come the normalising shifts and CORDIC_STEPS rotation steps. A new transaction is taken
// only when the block is idle and its finished result has moved into the output register;
// that register then holds the result while the next transaction runs.
module q_series_phase_kernel #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_write,
  input  wire logic [qspk_pkg::TermWidth-1:0]   cfg_data,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic signed [31:0]               q_real,
  input  wire logic signed [31:0]               q_imag,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic [15:0]                           phase_turn,
  output logic                                  saturated
);
  import qspk_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b00_0000_0001,
    S_DIFF  = 10'b00_0000_0010,
    S_MUL   = 10'b00_0000_0100,
    S_FIN   = 10'b00_0000_1000,
    S_CMBF  = 10'b00_0001_0000,
    S_ACC   = 10'b00_0010_0000,
    S_CMBP  = 10'b00_0100_0000,
    S_SETUP = 10'b00_1000_0000,
    S_NORM  = 10'b01_0000_0000,
    S_ROT   = 10'b10_0000_0000
  } state_t;

  localparam logic [4:0] LastStep = 5'(CORDIC_STEPS - 1);

  state_t state;
  logic [TermWidth-1:0] term_count;
  logic [TermWidth-1:0] n;
  logic [WordWidth-1:0] qr, qi, pr, pi, fr, fi, sr, si, dr, di;
  logic [WordWidth-1:0] prod [4];
  logic [2:0] idx;
  logic [1:0] pp;
  logic [127:0] acc;
  logic sat;
  logic [WordWidth-1:0] mx, my;
  logic u_neg, v_neg, zero_sum, rot_done;
  logic signed [CordicWidth-1:0] cx, cy;
  logic [31:0] z;
  logic [4:0] step;
  logic out_load;

  // Operand selection for the shared multiplier.
  logic [WordWidth-1:0] a_op, b_op, ua, ub, mm;
  logic [31:0] xa, xb;
  logic [63:0] pprod;
  logic [127:0] pp_ext, t_round, s_round;
  logic sh40, neg, mul_ovf;
  logic [WordWidth-1:0] mul_res;
  sat_res_t dr_s, di_s, fr_s, fi_s, sr_s, si_s, pr_s, pi_s;
  logic signed [CordicWidth-1:0] dx, dy;
  logic [31:0] a_fold;

  always_comb begin
    case (idx)
      3'd0: begin a_op = fr; b_op = dr; end
      3'd1: begin a_op = fi; b_op = di; end
      3'd2: begin a_op = fr; b_op = di; end
      3'd3: begin a_op = fi; b_op = dr; end
      3'd4: begin a_op = pr; b_op = qr; end
      3'd5: begin a_op = pi; b_op = qi; end
      3'd6: begin a_op = pr; b_op = qi; end
      default: begin a_op = pi; b_op = qr; end
    endcase
    sh40 = !idx[2];
    neg = a_op[WordWidth-1] ^ b_op[WordWidth-1];
    ua = mag(a_op);
    ub = mag(b_op);
    xa = pp[1] ? ua[63:32] : ua[31:0];
    xb = pp[0] ? ub[63:32] : ub[31:0];
    pprod = 64'(xa) * 64'(xb);
    case (pp)
      2'd0: pp_ext = {64'd0, pprod};
      2'd3: pp_ext = {pprod, 64'd0};
      default: pp_ext = {32'd0, pprod, 32'd0};
    endcase
    t_round = acc + (sh40 ? (128'd1 << 39) : (128'd1 << 29));
    s_round = sh40 ? (t_round >> 40) : (t_round >> 30);
    mul_ovf = (s_round[127:64] != 64'd0) ||
              (neg ? (s_round[63:0] > MinFix) : s_round[63]);
    if (mul_ovf) begin
      mul_res = neg ? MinFix : MaxFix;
    end else begin
      mul_res = neg ? (~s_round[63:0] + 64'd1) : s_round[63:0];
    end
  end

  assign dr_s = sat_sub(OneFix, pr);
  assign di_s = sat_sub(64'd0, pi);
  assign fr_s = sat_sub(prod[0], prod[1]);
  assign fi_s = sat_add(prod[2], prod[3]);
  assign sr_s = sat_add(sr, fr);
  assign si_s = sat_add(si, fi);
  assign pr_s = sat_sub(prod[0], prod[1]);
  assign pi_s = sat_add(prod[2], prod[3]);
  assign mm = (mx > my) ? mx : my;
  assign dx = cy >>> step;
  assign dy = cx >>> step;

  always_comb begin
    if (!u_neg && !v_neg) begin
      a_fold = z;
    end else if (u_neg && !v_neg) begin
      a_fold = HalfTurn - z;
    end else if (u_neg && v_neg) begin
      a_fold = HalfTurn + z;
    end else begin
      a_fold = 32'd0 - z;
    end
    if (zero_sum) begin
      a_fold = HalfTurn;
    end
  end

  // A finished result that has not yet reached the output register holds off new input.
  assign in_stall = (state != S_IDLE) || rot_done;
  assign out_load = (state == S_IDLE) && rot_done && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      term_count <= TermCountReset;
      out_valid <= 1'b0;
      rot_done <= 1'b0;
    end else begin
      if (cfg_write) begin
        term_count <= cfg_data;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (out_load) begin
            phase_turn <= 16'((a_fold + 32'h0000_8000) >> 16);
            saturated <= sat;
            rot_done <= 1'b0;
          end else if (in_valid && !rot_done) begin
            qr <= WordWidth'(q_real);
            qi <= WordWidth'(q_imag);
            pr <= {{22{q_real[31]}}, q_real, 10'd0};
            pi <= {{22{q_imag[31]}}, q_imag, 10'd0};
            fr <= OneFix;
            fi <= 64'd0;
            sr <= OneFix;
            si <= 64'd0;
            sat <= 1'b0;
            n <= TermWidth'(1);
            state <= (term_count > TermWidth'(1)) ? S_DIFF : S_SETUP;
          end
        end
        S_DIFF: begin
          dr <= dr_s.val;
          di <= di_s.val;
          sat <= sat | dr_s.ovf | di_s.ovf;
          idx <= 3'd0;
          pp <= 2'd0;
          state <= S_MUL;
        end
        S_MUL: begin
          acc <= ((pp == 2'd0) ? 128'd0 : acc) + pp_ext;
          pp <= pp + 2'd1;
          if (pp == 2'd3) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          prod[idx[1:0]] <= mul_res;
          sat <= sat | mul_ovf;
          if (idx == 3'd3) begin
            state <= S_CMBF;
          end else if (idx == 3'd7) begin
            state <= S_CMBP;
          end else begin
            idx <= idx + 3'd1;
            state <= S_MUL;
          end
        end
        S_CMBF: begin
          fr <= fr_s.val;
          fi <= fi_s.val;
          sat <= sat | fr_s.ovf | fi_s.ovf;
          state <= S_ACC;
        end
        S_ACC: begin
          sr <= sr_s.val;
          si <= si_s.val;
          sat <= sat | sr_s.ovf | si_s.ovf;
          idx <= 3'd4;
          state <= S_MUL;
        end
        S_CMBP: begin
          pr <= pr_s.val;
          pi <= pi_s.val;
          sat <= sat | pr_s.ovf | pi_s.ovf;
          n <= n + TermWidth'(1);
          state <= ((n + TermWidth'(1)) < term_count) ? S_DIFF : S_SETUP;
        end
        S_SETUP: begin
          mx <= mag(sr);
          my <= mag(si);
          u_neg <= !sr[WordWidth-1] && (sr != 64'd0);
          v_neg <= !si[WordWidth-1] && (si != 64'd0);
          zero_sum <= (sr == 64'd0) && (si == 64'd0);
          if ((sr == 64'd0) && (si == 64'd0)) begin
            rot_done <= 1'b1;
            state <= S_IDLE;
          end else begin
            state <= S_NORM;
          end
        end
        S_NORM: begin
          // One bit of shift a cycle until the larger magnitude lies in [2^29, 2^30).
          if (mm[63:30] != 34'd0) begin
            mx <= mx >> 1;
            my <= my >> 1;
          end else if (!mm[29]) begin
            mx <= mx << 1;
            my <= my << 1;
          end else begin
            cx <= CordicWidth'(mx[29:0]);
            cy <= CordicWidth'(my[29:0]);
            z <= 32'd0;
            step <= 5'd0;
            state <= S_ROT;
          end
        end
        S_ROT: begin
          if (!cy[CordicWidth-1]) begin
            cx <= cx + dx;
            cy <= cy - dy;
            z <= z + atan_turn(step);
          end else begin
            cx <= cx - dx;
            cy <= cy + dy;
            z <= z - atan_turn(step);
          end
          step <= step + 5'd1;
          if (step == LastStep) begin
            rot_done <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && !rot_done) |=> in_stall)
    else $error("block took a transaction but did not start work");

  a_out_from_result: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(rot_done))
    else $error("result presented without a finished evaluation");

  a_cordic_x_positive: assert property (@(posedge clk) disable iff (rst)
    (state == S_ROT) |-> !cx[CordicWidth-1])
    else $error("CORDIC x component went negative");

  a_pp_in_mul: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN) |-> $past(state == S_MUL) && (pp == 2'd0))
    else $error("product finished without four partial products");

endmodule
`default_nettype wire

[verif/tb_q_series_phase_kernel.sv]
// Self-checking testbench for the q-series phase kernel, with its own bit-exact predictor.
module tb_q_series_phase_kernel;
  import qspk_pkg::*;

  localparam int unsigned Steps = 16;
  localparam int unsigned RunLimit = 4_000_000;
  localparam int unsigned HoldCycles = 1500;

  typedef struct {
    logic [15:0] phase;
    logic        sat;
  } phase_result_t;

  // Arctangent of 2^-i as a fraction of a turn, scaled by 2^32.
  localparam logic [31:0] ArcTab [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
    32'h00000001, 32'h00000000};

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [TermWidth-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [31:0] q_real = '0;
  logic signed [31:0] q_imag = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [15:0] phase_turn;
  logic saturated;

  phase_result_t pending_phases[$];
  logic [TermWidth-1:0] terms_now = TermCountReset;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_requests = 0;
  int unsigned holds_served = 0;
  int unsigned hold_left = 0;
  int unsigned cycle_count = 0;
  int unsigned error_count = 0;
  int unsigned phases_checked = 0;
  int unsigned sat_seen = 0;

  q_series_phase_kernel u_dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .q_real(q_real), .q_imag(q_imag),
    .out_valid(out_valid), .out_stall(out_stall),
    .phase_turn(phase_turn), .saturated(saturated)
  );

  always #5 clk = ~clk;

  function automatic logic [63:0] abs64(input logic [63:0] v);
    return v[63] ? -v : v;
  endfunction

  // Exact product, rounded half away from zero, shifted down and clamped.
  function automatic logic [63:0] round_mul(input logic [63:0] a, input logic [63:0] b,
                                            input int sh, inout logic sat);
    logic neg;
    logic [127:0] p;
    logic [127:0] lim;
    neg = a[63] ^ b[63];
    p = {64'd0, abs64(a)} * {64'd0, abs64(b)};
    p = (p + (128'd1 << (sh - 1))) >> sh;
    lim = neg ? (128'd1 << 63) : ((128'd1 << 63) - 128'd1);
    if (p > lim) begin
      sat = 1'b1;
      return neg ? MinFix : MaxFix;
    end
    return neg ? -p[63:0] : p[63:0];
  endfunction

  function automatic logic [63:0] clamp_add(input logic [63:0] a, input logic [63:0] b,
                                            inout logic sat);
    logic [63:0] r;
    r = a + b;
    if (a[63] == b[63] && r[63] != a[63]) begin
      sat = 1'b1;
      return a[63] ? MinFix : MaxFix;
    end
    return r;
  endfunction

  function automatic logic [63:0] clamp_sub(input logic [63:0] a, input logic [63:0] b,
                                            inout logic sat);
    logic [63:0] r;
    r = a - b;
    if (a[63] != b[63] && r[63] != a[63]) begin
      sat = 1'b1;
      return a[63] ? MinFix : MaxFix;
    end
    return r;
  endfunction

  // Angle of (-x, -y) in 2^-32 turn, via first-quadrant vectoring and a quadrant fold.
  function automatic logic [31:0] reversed_angle(input logic [63:0] x, input logic [63:0] y);
    logic [63:0] mx, my, mm;
    longint cx, cy, dx, dy;
    logic [31:0] z;
    mx = abs64(x);
    my = abs64(y);
    z = '0;
    if (mx == 0 && my == 0) return HalfTurn;
    mm = (mx > my) ? mx : my;
    while (mm >= (64'd1 << 30)) begin
      mm >>= 1; mx >>= 1; my >>= 1;
    end
    while (mm < (64'd1 << 29)) begin
      mm <<= 1; mx <<= 1; my <<= 1;
    end
    cx = longint'(mx);
    cy = longint'(my);
    for (int i = 0; i < ((Steps > 32) ? 32 : Steps); i++) begin
      dx = cy >>> i;
      dy = cx >>> i;
      if (cy >= 0) begin
        cx += dx; cy -= dy; z += ArcTab[i];
      end else begin
        cx -= dx; cy += dy; z -= ArcTab[i];
      end
    end
    // x > 0 means the reversed vector points left; y > 0 means it points down.
    if (!($signed(x) > 0) && !($signed(y) > 0)) return z;
    if ($signed(x) > 0 && !($signed(y) > 0)) return HalfTurn - z;
    if ($signed(x) > 0) return HalfTurn + z;
    return -z;
  endfunction

  function automatic phase_result_t series_phase(input logic [31:0] qr, input logic [31:0] qi,
                                                 input logic [TermWidth-1:0] terms);
    logic [63:0] wr, wi, pr, pi, fr, fi, sr, si, dr, di, rr, ii, ri, ir, nr, ni;
    logic [31:0] ang;
    logic sat;
    phase_result_t res;
    wr = {{32{qr[31]}}, qr};
    wi = {{32{qi[31]}}, qi};
    pr = wr << 10;
    pi = wi << 10;
    fr = OneFix; fi = '0; sr = OneFix; si = '0;
    sat = 1'b0;
    for (int unsigned n = 1; n < terms; n++) begin
      dr = clamp_sub(OneFix, pr, sat);
      di = clamp_sub(64'd0, pi, sat);
      rr = round_mul(fr, dr, 40, sat);
      ii = round_mul(fi, di, 40, sat);
      ri = round_mul(fr, di, 40, sat);
      ir = round_mul(fi, dr, 40, sat);
      fr = clamp_sub(rr, ii, sat);
      fi = clamp_add(ri, ir, sat);
      sr = clamp_add(sr, fr, sat);
      si = clamp_add(si, fi, sat);
      rr = round_mul(pr, wr, 30, sat);
      ii = round_mul(pi, wi, 30, sat);
      ri = round_mul(pr, wi, 30, sat);
      ir = round_mul(pi, wr, 30, sat);
      nr = clamp_sub(rr, ii, sat);
      ni = clamp_add(ri, ir, sat);
      pr = nr;
      pi = ni;
    end
    ang = reversed_angle(sr, si) + 32'h8000;
    res.phase = ang[31:16];
    res.sat = sat;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("MISMATCH %s: got %0h, expected %0h (cycle %0d)", what, got, want, cycle_count);
    error_count++;
  endtask

  always @(posedge clk) begin
    phase_result_t want;
    cycle_count <= cycle_count + 1;
    if (cycle_count > RunLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("simulation failed");
      $finish;
    end
    if (!rst && out_valid && !out_stall) begin
      if (pending_phases.size() == 0) begin
        report_mismatch("unexpected transaction", phase_turn, 16'h0);
      end else begin
        want = pending_phases.pop_front();
        phases_checked++;
        if (want.sat) sat_seen++;
        if (phase_turn !== want.phase) report_mismatch("phase_turn", phase_turn, want.phase);
        if (saturated !== want.sat) begin
          report_mismatch("saturated", 16'(saturated), 16'(want.sat));
        end
      end
    end
  end

  // Receiver: a long hold-off overrides the random stall.
  always @(posedge clk) begin
    if (holds_served != hold_requests) begin
      holds_served <= holds_served + 1;
      hold_left <= HoldCycles;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic send_q(input logic [31:0] qr, input logic [31:0] qi);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    q_real <= qr;
    q_imag <= qi;
    do @(posedge clk); while (in_stall);
    pending_phases.push_back(series_phase(qr, qi, terms_now));
  endtask

  task automatic stop_sending();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    while (pending_phases.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic set_terms(input logic [TermWidth-1:0] v);
    cfg_write <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_write <= 1'b0;
    terms_now = v;
    @(posedge clk);
  endtask

  function automatic logic [31:0] random_q_part(input int unsigned kind);
    case (kind)
      0: return $urandom_range(32'h3FFF_FFFF) - 32'h2000_0000;
      1: return $urandom_range(32'h7FFF_FFFF) - 32'h4000_0000;
      default: return $urandom;
    endcase
  endfunction

  // Extremes of q at the reset term count, including zero and both corners.
  task automatic test_extreme_points();
    send_q(32'h0000_0000, 32'h0000_0000);
    send_q(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_q(32'h8000_0000, 32'h8000_0000);
    send_q(32'h4000_0000, 32'h0000_0000);
    send_q(32'h0000_0000, 32'hC000_0000);
    send_q(32'h2000_0000, 32'h2000_0000);
    stop_sending();
    drain();
  endtask

  // Zero and one term give a phase of half a turn; one point at 4096 terms.
  task automatic test_term_counts();
    set_terms(13'd0);
    send_q(32'h8000_0000, 32'h7FFF_FFFF);
    stop_sending();
    drain();
    set_terms(13'd1);
    send_q(32'h7FFF_FFFF, 32'h8000_0000);
    stop_sending();
    drain();
    set_terms(13'd2);
    send_q(32'h4000_0000, 32'h0000_0000);  // q of one makes the only product vanish
    send_q(32'hFFFF_FFFF, 32'h0000_0001);
    send_q(32'h8000_0000, 32'h0000_0000);
    send_q(32'h0000_0000, 32'h7FFF_FFFF);
    stop_sending();
    drain();
    set_terms(13'd4096);
    send_q(32'h1800_0000, 32'hE000_0000);
    stop_sending();
    drain();
  endtask

  task automatic test_random_points(input int unsigned idle_s, input int unsigned idle_r,
                                    input int unsigned count);
    send_idle_pct = idle_s;
    recv_stall_pct = idle_r;
    for (int unsigned k = 0; k < count; k++) begin
      if (k % 30 == 0) begin
        stop_sending();
        drain();
        set_terms(($urandom_range(19) == 0) ? 13'd64 : 13'($urandom_range(12, 1)));
      end
      send_q(random_q_part($urandom_range(2)), random_q_part($urandom_range(2)));
    end
    stop_sending();
    drain();
  endtask

  task automatic test_output_holdoff();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    set_terms(13'd2);
    hold_requests++;
    for (int unsigned k = 0; k < 20; k++) send_q($urandom, $urandom);
    stop_sending();
    drain();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_extreme_points();
    test_term_counts();
    test_random_points(10, 80, 170);
    test_random_points(80, 10, 170);
    test_random_points(0, 0, 170);
    test_output_holdoff();
    $display("checked %0d results, %0d of them saturated, term counts 0 to 4096",
             phases_checked, sat_seen);
    $display("random phases ran with sender gaps, receiver stalls and a long hold-off");
    if (error_count == 0 && pending_phases.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
